>>> sv/pbas_pkg.sv
// Shared types, constants and the decimal byte add step for the packed BCD adder/subtractor.
// No dependencies.
package pbas_pkg;

  // default number of byte lanes
  localparam int BYTES_DEF = 4;

  // decimal arithmetic constants
  localparam logic [7:0] BCD_NINES = 8'h99;
  localparam logic [3:0] DIGIT_MAX = 4'h9;
  localparam logic [9:0] ADJ_LO    = 10'h006;
  localparam logic [9:0] ADJ_HI    = 10'h060;
  localparam logic [9:0] HI_LIMIT  = 10'h0A0;

  // one lane step result: carry in [9:8], byte in [7:0]
  typedef logic [9:0] step_t;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [2:0]  byte_count;
    logic        mode;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result;
    logic        carry_out;
  } out_word_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic comp_en;
    logic sum_en;
    logic sub;
    logic inc;
  } lane_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_SUM,
    ST_MERGE
  } state_t;

  // decimal add of two bytes with a carry in of 0..2
  function automatic step_t bcd_step(input logic [7:0] x, input logic [7:0] y,
                                     input logic [1:0] cin);
    logic [9:0] sum;
    logic [7:0] hi;
    sum = 10'(x) + 10'(y) + 10'(cin);
    hi  = {x[7:4], 4'h0} + {y[7:4], 4'h0};
    if ((hi[7:4] != sum[7:4]) || (sum[3:0] > DIGIT_MAX)) begin
      sum = sum + ADJ_LO;
    end
    if (sum >= HI_LIMIT) begin
      sum = sum + ADJ_HI;
    end
    return sum;
  endfunction

endpackage

>>> sv/packed_bcd_add_sub.sv
// Packed BCD adder/subtractor top level: sequencer, byte lanes and carry merge.
// The complement, lane sum and merge steps run in turn on one word at a time, so the next word
// is taken only once the last result has been loaded into the output register.
// A finished result waits in the output register while the next word is taken.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output register.
// Depends on pbas_pkg, pbas_lane, pbas_merge.
module packed_bcd_add_sub import pbas_pkg::*; #(
  parameter int BYTES = BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  in_word_t  src_word,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_word_t dst_word
);

  localparam int W  = 8 * BYTES;
  localparam int CW = $clog2(BYTES + 1);

  state_t state;
  state_t state_next;

  logic [W-1:0]  a_ext;
  logic [W-1:0]  b_ext;
  logic [CW-1:0] cnt;
  logic          sub;

  logic [BYTES-1:0]       b_zero;
  logic [BYTES-1:0]       inc;
  step_t [BYTES-1:0][2:0] sums;
  logic [W-1:0]           res;
  logic                   carry_out;
  logic                   load_out;

  assign src_ready = (state == ST_IDLE);
  assign load_out  = (state == ST_MERGE) && (!dst_valid || dst_ready);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (src_valid) state_next = ST_COMP;
      ST_COMP:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_MERGE;
      ST_MERGE: if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // capture the input word, count saturated to the lane count
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      a_ext <= W'(src_word.operand_a);
      b_ext <= W'(src_word.operand_b);
      sub   <= src_word.mode;
      if (int'(src_word.byte_count) > BYTES) begin
        cnt <= CW'(BYTES);
      end else begin
        cnt <= CW'(src_word.byte_count);
      end
    end
  end

  // increment of the ten's complement ripples past zero bytes
  always_comb begin
    inc[0] = 1'b1;
    for (int i = 1; i < BYTES; i++) begin
      inc[i] = inc[i-1] && b_zero[i-1];
    end
  end

  // byte lanes
  for (genvar g = 0; g < BYTES; g++) begin : g_lane
    lane_ctl_t ctl;
    assign ctl.comp_en = (state == ST_COMP);
    assign ctl.sum_en  = (state == ST_SUM);
    assign ctl.sub     = sub;
    assign ctl.inc     = inc[g];

    pbas_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .a_byte (a_ext[8*g +: 8]),
      .b_byte (b_ext[8*g +: 8]),
      .b_zero (b_zero[g]),
      .sums   (sums[g])
    );
  end

  // carry merge
  pbas_merge #(
    .BYTES (BYTES)
  ) u_merge (
    .sums      (sums),
    .a_ext     (a_ext),
    .cnt       (cnt),
    .sub       (sub),
    .res       (res),
    .carry_out (carry_out)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (load_out) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      dst_word.result    <= 32'(res);
      dst_word.carry_out <= carry_out;
    end
  end

endmodule

>>> sv/pbas_lane.sv
// One byte lane: ten's complement of the second operand byte when subtracting, then carry-select sums.
// Depends on pbas_pkg.
module pbas_lane import pbas_pkg::*; (
  input  logic          clk,
  input  lane_ctl_t     ctl,
  input  logic [7:0]    a_byte,
  input  logic [7:0]    b_byte,
  output logic          b_zero,
  output step_t [2:0]   sums
);

  logic [7:0] comp;
  logic [7:0] comp_next;
  logic [7:0] nines;

  // nines complement plus the rippled increment when subtracting, else the byte unchanged
  always_comb begin
    nines     = BCD_NINES - b_byte;
    comp_next = b_byte;
    if (ctl.sub) begin
      comp_next = nines;
      if (ctl.inc) begin
        if (nines == BCD_NINES) begin
          comp_next = 8'h00;
        end else if (nines[3:0] == DIGIT_MAX) begin
          comp_next = {nines[7:4] + 4'd1, 4'h0};
        end else begin
          comp_next = nines + 8'd1;
        end
      end
    end
  end

  // increment keeps rippling only past zero bytes
  assign b_zero = (b_byte == 8'h00);

  // complement register, then sums for each possible carry in
  always_ff @(posedge clk) begin
    if (ctl.comp_en) begin
      comp <= comp_next;
    end
    if (ctl.sum_en) begin
      for (int k = 0; k < 3; k++) begin
        sums[k] <= bcd_step(a_byte, comp, 2'(k));
      end
    end
  end

endmodule

>>> sv/pbas_merge.sv
// Carry merge across byte lanes: picks each lane's precomputed sum by the incoming carry.
// Depends on pbas_pkg.
module pbas_merge import pbas_pkg::*; #(
  parameter int BYTES = BYTES_DEF,
  localparam int W    = 8 * BYTES,
  localparam int CW   = $clog2(BYTES + 1)
) (
  input  step_t [BYTES-1:0][2:0] sums,
  input  logic [W-1:0]           a_ext,
  input  logic [CW-1:0]          cnt,
  input  logic                   sub,
  output logic [W-1:0]           res,
  output logic                   carry_out
);

  logic [1:0] carry;
  step_t      sel;

  // ripple the carry through the used lanes, upper bytes pass from operand a
  always_comb begin
    carry = 2'd0;
    sel   = '0;
    res   = a_ext;
    for (int i = 0; i < BYTES; i++) begin
      if (i < int'(cnt)) begin
        sel              = sums[i][carry];
        res[8*i +: 8]    = sel[7:0];
        carry            = sel[9:8];
      end
    end
    carry_out = !sub && (carry != 2'd0);
  end

endmodule
